[sv/crg_pkg.sv]
// Shared constants and types of the camera ray generator.
`timescale 1ns / 1ps

package crg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int NUM_REGS       = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int WORD_BITS      = 32;
    localparam int PITCH_BITS     = 31;
    localparam int SHIFT_BITS     = 6;
    localparam int Z_SHIFT        = 14;

    localparam int SQRT_STEPS = 32;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;
    localparam int DIV_STEPS  = 31;
    localparam int DIV_LAT    = DIV_STEPS + 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ROW0_LEFT  = 3'd0,
        REG_ROW0_RIGHT = 3'd1,
        REG_ROW1_LEFT  = 3'd2,
        REG_ROW1_RIGHT = 3'd3,
        REG_ROW2_LEFT  = 3'd4,
        REG_ROW2_RIGHT = 3'd5,
        REG_HALF       = 3'd6,
        REG_PITCH      = 3'd7
    } cfg_reg_t;

    localparam logic [CFG_DATA_BITS-1:0] REG_RESET [0:NUM_REGS-1] = '{
        64'h0000_0001_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0001_0000_0001_0000,
        64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } ray_ctrl_t;

    typedef struct packed {
        ray_ctrl_t                  ctrl;
        logic [2:0][WORD_BITS-1:0] mag;
    } ray_side_t;

endpackage

[sv/camera_ray_generator_top.sv]
// Pinhole camera primary ray generator: pixel in, world-space ray out.
//
//  channel   signals                                   direction
//  request   in_valid / in_ready, pixel_x, pixel_y     in
//  ray       out_valid / out_ready, origin_*, dir_*,   out
//            degenerate
//  config    cfg_write, cfg_index, cfg_data            in
//
//  One ray per clock while the ray output is not stalled.
//  The pipeline runs through the 32-stage square root and then the 31-stage divider.
//  Reset clears all valid bits and loads the REG_RESET values into the camera registers.
//  A stalled ray holds the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps

module camera_ray_generator_top #(
    parameter int COORD_BITS = crg_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [COORD_BITS-1:0]                pixel_x,
    input  logic [COORD_BITS-1:0]                pixel_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   origin_x,
    output logic signed [31:0]                   origin_y,
    output logic signed [31:0]                   origin_z,
    output logic signed [31:0]                   dir_x,
    output logic signed [31:0]                   dir_y,
    output logic signed [31:0]                   dir_z,
    output logic                                 degenerate,
    input  logic                                 cfg_write,
    input  logic [crg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [crg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int PW = COORD_BITS + 32;
    localparam int TW = PW + 2;
    localparam int W  = crg_pkg::WORD_BITS;

    function automatic logic [W-1:0] canvas(input logic [W-1:0] half,
                                            input logic [PW-1:0] prod);
        logic [TW-1:0]        t;
        logic signed [TW-1:0] h;
        t = {{(TW-W-1){half[W-1]}}, half, 1'b0} - {2'b00, prod} + TW'(1);
        h = $signed(t) >>> 1;
        if (h[TW-1:W-1] == '0 || h[TW-1:W-1] == '1)
            canvas = h[W-1:0];
        else
            canvas = h[TW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    logic [crg_pkg::CFG_DATA_BITS-1:0] cfg_reg [0:crg_pkg::NUM_REGS-1];
    logic en;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                 s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic [PW-1:0]        s1_prod_x_reg, s1_prod_y_reg;
    logic [W-1:0]         s2_cx_reg, s2_cy_reg;
    logic signed [63:0]   s3_p_reg [0:2][0:1];
    logic signed [63:0]   s4_d_reg [0:2];
    logic signed [63:0]   s5_d_reg [0:2];
    logic [63:0]          s5_max_reg;
    logic signed [63:0]   s6_d_reg [0:2];
    logic [crg_pkg::SHIFT_BITS-1:0] s6_shift_reg;
    logic                 s6_degen_reg;
    logic [W-1:0]         s7_mag_reg [0:2];
    logic [2:0]           s7_neg_reg;
    logic                 s7_degen_reg;
    logic [63:0]          s8_sq_reg [0:2];
    logic [W-1:0]         s8_mag_reg [0:2];
    logic [2:0]           s8_neg_reg;
    logic                 s8_degen_reg;

    crg_pkg::ray_side_t   line_a_reg [0:crg_pkg::SQRT_LAT-1];
    crg_pkg::ray_ctrl_t   line_b_reg [0:crg_pkg::DIV_LAT-1];

    logic [W-1:0]         root;
    logic [W-1:0]         len;
    logic [crg_pkg::DIV_STEPS-1:0] quot [0:2];

    logic                 out_valid_reg;
    logic [W-1:0]         dir_reg [0:2];
    logic                 degen_reg;

    logic [63:0]          mag5 [0:2];
    logic [63:0]          max5;
    logic [crg_pkg::SHIFT_BITS-1:0] shift6;
    logic signed [63:0]   v7 [0:2];
    logic [63:0]          neg7 [0:2];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < crg_pkg::NUM_REGS; k++)
                cfg_reg[k] <= crg_pkg::REG_RESET[k];
        end
        else if (cfg_write)
        begin
            if (cfg_index == crg_pkg::REG_PITCH)
                cfg_reg[cfg_index] <= {{(crg_pkg::CFG_DATA_BITS-crg_pkg::PITCH_BITS){1'b0}},
                                       cfg_data[crg_pkg::PITCH_BITS-1:0]};
            else
                cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        max5 = '0;
        for (int r = 0; r < 3; r++)
        begin
            mag5[r] = s4_d_reg[r][63] ? 64'(-s4_d_reg[r]) : 64'(s4_d_reg[r]);
        end
        for (int r = 0; r < 3; r++)
        begin
            if (mag5[r] > max5)
                max5 = mag5[r];
        end
    end

    always_comb
    begin
        shift6 = '0;
        for (int b = W - 1; b < 63; b++)
        begin
            if (s5_max_reg[b])
                shift6 = crg_pkg::SHIFT_BITS'(b - (W - 2));
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            v7[r]   = s6_d_reg[r] >>> s6_shift_reg;
            neg7[r] = 64'(-v7[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            out_valid_reg <= line_b_reg[crg_pkg::DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_x_reg <= PW'({pixel_x, 1'b1}) *
                             PW'(cfg_reg[crg_pkg::REG_PITCH][crg_pkg::PITCH_BITS-1:0]);
            s1_prod_y_reg <= PW'({pixel_y, 1'b1}) *
                             PW'(cfg_reg[crg_pkg::REG_PITCH][crg_pkg::PITCH_BITS-1:0]);

            s2_cx_reg <= canvas(cfg_reg[crg_pkg::REG_HALF][63:32], s1_prod_x_reg);
            s2_cy_reg <= canvas(cfg_reg[crg_pkg::REG_HALF][31:0], s1_prod_y_reg);

            for (int r = 0; r < 3; r++)
            begin
                s3_p_reg[r][0] <= 64'($signed(cfg_reg[2*r][63:32])) * 64'($signed(s2_cx_reg));
                s3_p_reg[r][1] <= 64'($signed(cfg_reg[2*r][31:0])) * 64'($signed(s2_cy_reg));
                s4_d_reg[r]    <= (s3_p_reg[r][0] >>> 2) + (s3_p_reg[r][1] >>> 2)
                                - (64'($signed(cfg_reg[2*r+1][63:32])) <<< crg_pkg::Z_SHIFT);
                s5_d_reg[r]    <= s4_d_reg[r];
                s6_d_reg[r]    <= s5_d_reg[r];
                s7_mag_reg[r]  <= v7[r][63] ? neg7[r][W-1:0] : v7[r][W-1:0];
                s8_sq_reg[r]   <= 64'(s7_mag_reg[r]) * 64'(s7_mag_reg[r]);
                s8_mag_reg[r]  <= s7_mag_reg[r];
                s7_neg_reg[r]  <= s6_d_reg[r][63];
            end

            s5_max_reg   <= max5;
            s6_shift_reg <= shift6;
            s6_degen_reg <= s5_max_reg == '0;
            s7_degen_reg <= s6_degen_reg;
            s8_neg_reg   <= s7_neg_reg;
            s8_degen_reg <= s7_degen_reg;
        end
    end

    crg_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (s8_sq_reg[0] + s8_sq_reg[1] + s8_sq_reg[2]),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < crg_pkg::SQRT_LAT; k++)
                line_a_reg[k] <= '0;
            for (int k = 0; k < crg_pkg::DIV_LAT; k++)
                line_b_reg[k] <= '0;
        end
        else if (en)
        begin
            line_a_reg[0].ctrl.valid <= s8_valid_reg;
            line_a_reg[0].ctrl.degen <= s8_degen_reg;
            line_a_reg[0].ctrl.neg   <= s8_neg_reg;
            for (int r = 0; r < 3; r++)
                line_a_reg[0].mag[r] <= s8_mag_reg[r];
            for (int k = 1; k < crg_pkg::SQRT_LAT; k++)
                line_a_reg[k] <= line_a_reg[k-1];
            line_b_reg[0] <= line_a_reg[crg_pkg::SQRT_LAT-1].ctrl;
            for (int k = 1; k < crg_pkg::DIV_LAT; k++)
                line_b_reg[k] <= line_b_reg[k-1];
        end
    end

    assign len = (root == '0) ? W'(1) : root;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            crg_div u_div (
                .clk      (clk),
                .en       (en),
                .mag      (line_a_reg[crg_pkg::SQRT_LAT-1].mag[g]),
                .divisor  (len),
                .quotient (quot[g])
            );

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (line_b_reg[crg_pkg::DIV_LAT-1].degen)
                        dir_reg[g] <= '0;
                    else if (line_b_reg[crg_pkg::DIV_LAT-1].neg[g])
                        dir_reg[g] <= W'(0) - W'(quot[g]);
                    else
                        dir_reg[g] <= W'(quot[g]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            degen_reg <= line_b_reg[crg_pkg::DIV_LAT-1].degen;
    end

    assign out_valid  = out_valid_reg;
    assign origin_x   = cfg_reg[crg_pkg::REG_ROW0_RIGHT][31:0];
    assign origin_y   = cfg_reg[crg_pkg::REG_ROW1_RIGHT][31:0];
    assign origin_z   = cfg_reg[crg_pkg::REG_ROW2_RIGHT][31:0];
    assign dir_x      = dir_reg[0];
    assign dir_y      = dir_reg[1];
    assign dir_z      = dir_reg[2];
    assign degenerate = degen_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> dir_x == 0 && dir_y == 0 && dir_z == 0)
        else $error("degenerate ray carries a nonzero direction");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |->
            dir_x <= 32'sh4000_0000 && dir_x >= -32'sh4000_0000 &&
            dir_y <= 32'sh4000_0000 && dir_y >= -32'sh4000_0000 &&
            dir_z <= 32'sh4000_0000 && dir_z >= -32'sh4000_0000)
        else $error("direction component above unit length");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(line_b_reg[crg_pkg::DIV_LAT-1].valid))
        else $error("ray appeared without an item at the divider output");

endmodule

[sv/crg_sqrt.sv]
// Pipelined 64-bit integer square root, one result bit per stage.
`timescale 1ns / 1ps

module crg_sqrt (
    input  logic                            clk,
    input  logic                            en,
    input  logic [63:0]                     radicand,
    output logic [crg_pkg::WORD_BITS-1:0]   root
);

    localparam int STEPS = crg_pkg::SQRT_STEPS;

    logic [63:0] n_reg   [0:STEPS];
    logic [63:0] res_reg [0:STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= radicand;
            res_reg[0] <= '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
            logic [63:0] trial;

            assign trial = res_reg[i] + BIT;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (n_reg[i] >= trial)
                    begin
                        n_reg[i+1]   <= n_reg[i] - trial;
                        res_reg[i+1] <= (res_reg[i] >> 1) + BIT;
                    end
                    else
                    begin
                        n_reg[i+1]   <= n_reg[i];
                        res_reg[i+1] <= res_reg[i] >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = res_reg[STEPS][crg_pkg::WORD_BITS-1:0];

endmodule

[sv/crg_div.sv]
// Pipelined rounding divider for one direction component, one quotient bit per stage.
`timescale 1ns / 1ps

module crg_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic [crg_pkg::WORD_BITS-1:0]     mag,
    input  logic [crg_pkg::WORD_BITS-1:0]     divisor,
    output logic [crg_pkg::DIV_STEPS-1:0]     quotient
);

    localparam int STEPS = crg_pkg::DIV_STEPS;
    localparam int W     = crg_pkg::WORD_BITS;
    localparam int NW    = W + 30;

    logic [NW-1:0]    num;
    logic [W-1:0]     rem_reg [0:STEPS];
    logic [W-1:0]     den_reg [0:STEPS];
    logic [STEPS-1:0] low_reg [0:STEPS];

    assign num = {mag, 30'b0} + {{(NW-W+1){1'b0}}, divisor[W-1:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {{(W-(NW-STEPS)){1'b0}}, num[NW-1:STEPS]};
            low_reg[0] <= num[STEPS-1:0];
            den_reg[0] <= divisor;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic [W:0] shifted;
            logic [W:0] diff;
            logic       take;

            assign shifted = {rem_reg[i], low_reg[i][STEPS-1]};
            assign diff    = shifted - {1'b0, den_reg[i]};
            assign take    = shifted >= {1'b0, den_reg[i]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= take ? diff[W-1:0] : shifted[W-1:0];
                    low_reg[i+1] <= {low_reg[i][STEPS-2:0], take};
                    den_reg[i+1] <= den_reg[i];
                end
            end
        end
    endgenerate

    assign quotient = low_reg[STEPS];

endmodule

[verif/camera_ray_generator_top_tb.sv]
// Testbench for the camera ray generator: predicted rays checked against the block's output.
`timescale 1ns / 1ps

module camera_ray_generator_top_tb;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  DRAIN_CYCLES = 100;

    typedef struct {
        logic signed [31:0] ox, oy, oz;
        logic signed [31:0] dx, dy, dz;
        logic               degen;
    } ray_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] origin_x, origin_y, origin_z;
    logic signed [31:0] dir_x, dir_y, dir_z;
    logic               degenerate;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;

    logic [63:0] cam_regs [0:crg_pkg::NUM_REGS-1];
    ray_t        ray_q [$];
    int          err_count;
    int          cycle_count;
    int          send_pct;
    int          recv_pct;
    int          hold_cycles;

    camera_ray_generator_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .degenerate (degenerate),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n   -= res + b;
                res  = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint canvas_point(longint half, logic [11:0] idx, longint pitch);
        longint t;
        t = 2 * half - (2 * longint'(idx) + 1) * pitch;
        t = (t + 1) >>> 1;
        if (t > 64'sd2147483647)
            t = 64'sd2147483647;
        if (t < -64'sd2147483648)
            t = -64'sd2147483648;
        return t;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py);
        ray_t            r;
        longint          c [3];
        longint          d [3];
        longint          v [3];
        longint          m0, m1, m2;
        longint unsigned maxm, sumsq, len, q;
        int              s;
        maxm  = 0;
        sumsq = 0;
        s     = 0;
        c[0] = canvas_point(longint'($signed(cam_regs[crg_pkg::REG_HALF][63:32])), px,
                            longint'({1'b0, cam_regs[crg_pkg::REG_PITCH][30:0]}));
        c[1] = canvas_point(longint'($signed(cam_regs[crg_pkg::REG_HALF][31:0])), py,
                            longint'({1'b0, cam_regs[crg_pkg::REG_PITCH][30:0]}));
        c[2] = -65536;
        for (int k = 0; k < 3; k++)
        begin
            m0 = longint'($signed(cam_regs[2*k][63:32]));
            m1 = longint'($signed(cam_regs[2*k][31:0]));
            m2 = longint'($signed(cam_regs[2*k+1][63:32]));
            d[k] = ((m0 * c[0]) >>> 2) + ((m1 * c[1]) >>> 2) + ((m2 * c[2]) >>> 2);
            if (abs64(d[k]) > maxm)
                maxm = abs64(d[k]);
        end
        r.ox = cam_regs[crg_pkg::REG_ROW0_RIGHT][31:0];
        r.oy = cam_regs[crg_pkg::REG_ROW1_RIGHT][31:0];
        r.oz = cam_regs[crg_pkg::REG_ROW2_RIGHT][31:0];
        if (maxm == 0)
        begin
            r.dx    = '0;
            r.dy    = '0;
            r.dz    = '0;
            r.degen = 1'b1;
            return r;
        end
        while ((maxm >> s) >= 64'h8000_0000)
            s++;
        for (int k = 0; k < 3; k++)
        begin
            v[k]   = d[k] >>> s;
            sumsq += abs64(v[k]) * abs64(v[k]);
        end
        len = root_floor(sumsq);
        if (len == 0)
            len = 1;
        for (int k = 0; k < 3; k++)
        begin
            q = ((abs64(v[k]) << 30) + (len >> 1)) / len;
            v[k] = (d[k] < 0) ? -longint'(q) : longint'(q);
        end
        r.dx    = v[0][31:0];
        r.dy    = v[1][31:0];
        r.dz    = v[2][31:0];
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want, cycle_count);
        err_count++;
    endtask

    // ray checker
    always @(posedge clk)
    begin
        ray_t exp_ray;
        if (rst_n && out_valid && out_ready)
        begin
            if (ray_q.size() == 0)
                report_mismatch("unexpected ray", 0, 0);
            else
            begin
                exp_ray = ray_q.pop_front();
                if (origin_x !== exp_ray.ox)
                    report_mismatch("origin_x", origin_x, exp_ray.ox);
                if (origin_y !== exp_ray.oy)
                    report_mismatch("origin_y", origin_y, exp_ray.oy);
                if (origin_z !== exp_ray.oz)
                    report_mismatch("origin_z", origin_z, exp_ray.oz);
                if (dir_x !== exp_ray.dx)
                    report_mismatch("dir_x", dir_x, exp_ray.dx);
                if (dir_y !== exp_ray.dy)
                    report_mismatch("dir_y", dir_y, exp_ray.dy);
                if (dir_z !== exp_ray.dz)
                    report_mismatch("dir_z", dir_z, exp_ray.dz);
                if (degenerate !== exp_ray.degen)
                    report_mismatch("degenerate", degenerate, exp_ray.degen);
            end
        end
    end

    // ray receiver
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_pct);
        end
    end

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        int gap;
        if ($urandom_range(99) < send_pct)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= px;
        pixel_y  <= py;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        ray_q.push_back(predict_ray(px, py));
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        end_burst();
        while (ray_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(logic [63:0] vals [0:crg_pkg::NUM_REGS-1]);
        for (int i = 0; i < crg_pkg::NUM_REGS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= crg_pkg::cfg_reg_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            cam_regs[i] = (i == crg_pkg::REG_PITCH) ? {33'b0, vals[i][30:0]} : vals[i];
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] near_word();
        return 32'($signed(18'($urandom)));
    endfunction

    task automatic random_camera();
        logic [63:0] vals [0:crg_pkg::NUM_REGS-1];
        bit          wide;
        wide = ($urandom_range(3) == 0);
        for (int i = 0; i < crg_pkg::REG_HALF; i++)
            vals[i] = wide ? {$urandom, $urandom} : {near_word(), near_word()};
        vals[crg_pkg::REG_HALF]  = wide ? {$urandom, $urandom}
                               : {32'($signed(23'($urandom))), 32'($signed(23'($urandom)))};
        vals[crg_pkg::REG_PITCH] = wide ? {$urandom, $urandom} : 64'($urandom_range(1, 4096));
        write_regs(vals);
    endtask

    task automatic test_reset_camera();
        send_pixel(12'h000, 12'h000);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'h000, 12'hFFF);
        send_pixel(12'hFFF, 12'h000);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        wait_idle();
    endtask

    task automatic test_zero_difference();
        logic [63:0] vals [0:crg_pkg::NUM_REGS-1];
        for (int i = 0; i < crg_pkg::NUM_REGS; i++)
            vals[i] = 64'h0000_0000_1234_5678;
        vals[crg_pkg::REG_ROW0_LEFT]  = '0;
        vals[crg_pkg::REG_ROW1_LEFT]  = '0;
        vals[crg_pkg::REG_ROW2_LEFT]  = '0;
        write_regs(vals);
        send_pixel(12'h000, 12'h000);
        send_pixel(12'hFFF, 12'h7FF);
        send_pixel(12'h123, 12'hFFF);
        wait_idle();
    endtask

    task automatic test_extremes();
        logic [63:0] vals [0:crg_pkg::NUM_REGS-1];
        vals[crg_pkg::REG_ROW0_LEFT]  = 64'h8000_0000_7FFF_FFFF;
        vals[crg_pkg::REG_ROW0_RIGHT] = 64'h8000_0000_7FFF_FFFF;
        vals[crg_pkg::REG_ROW1_LEFT]  = 64'h7FFF_FFFF_8000_0000;
        vals[crg_pkg::REG_ROW1_RIGHT] = 64'h7FFF_FFFF_8000_0000;
        vals[crg_pkg::REG_ROW2_LEFT]  = 64'h8000_0000_8000_0000;
        vals[crg_pkg::REG_ROW2_RIGHT] = 64'hFFFF_FFFF_FFFF_FFFF;
        vals[crg_pkg::REG_HALF]       = 64'h7FFF_FFFF_8000_0000;
        vals[crg_pkg::REG_PITCH]      = 64'hFFFF_FFFF_FFFF_FFFF;
        write_regs(vals);
        send_pixel(12'h000, 12'h000);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'h800, 12'h001);
        wait_idle();
        vals[crg_pkg::REG_HALF]  = 64'h8000_0000_7FFF_FFFF;
        vals[crg_pkg::REG_PITCH] = 64'h0;
        write_regs(vals);
        send_pixel(12'hFFF, 12'h000);
        send_pixel(12'h000, 12'hFFF);
        wait_idle();
        vals[crg_pkg::REG_ROW0_LEFT]  = 64'h0;
        vals[crg_pkg::REG_ROW1_LEFT]  = 64'h0;
        vals[crg_pkg::REG_ROW2_LEFT]  = 64'h0;
        vals[crg_pkg::REG_ROW0_RIGHT] = 64'h0000_0001_0000_0000;
        vals[crg_pkg::REG_ROW1_RIGHT] = 64'h0;
        vals[crg_pkg::REG_ROW2_RIGHT] = 64'h0;
        write_regs(vals);
        send_pixel(12'h7FF, 12'h800);
        wait_idle();
    endtask

    task automatic test_random_cameras(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            random_camera();
            for (int n = 0; n < per_phase; n++)
                send_pixel(12'($urandom), 12'($urandom));
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        random_camera();
        hold_cycles = 400;
        for (int n = 0; n < 150; n++)
            send_pixel(12'($urandom), 12'($urandom));
        wait_idle();
        for (int n = 0; n < 20; n++)
            send_pixel(12'($urandom), 12'($urandom));
        wait_idle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pixel_x     = '0;
        pixel_y     = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        err_count   = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_pct    = 7;
        recv_pct    = 77;
        for (int i = 0; i < crg_pkg::NUM_REGS; i++)
            cam_regs[i] = crg_pkg::REG_RESET[i];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_camera();
        test_zero_difference();
        test_extremes();
        test_random_cameras(8, 50);
        send_pct = 77;
        recv_pct = 7;
        test_random_cameras(8, 50);
        send_pct = 0;
        recv_pct = 0;
        test_random_cameras(6, 75);
        test_backpressure();

        wait_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
